// File: hw/rtl/imu_six_axis_smoothing_filter_top_macros.svh
// Assertion macros shared by the IMU smoothing filter RTL.
`ifndef IMU_SIX_AXIS_SMOOTHING_FILTER_TOP_MACROS_SVH
`define IMU_SIX_AXIS_SMOOTHING_FILTER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Checked only while out of reset.
`define IMUSF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define IMUSF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define IMUSF_ASSERT(lbl, clk, rst_n, prop, msg)
`define IMUSF_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// File: hw/rtl/imusf_pkg.sv
// Types and constants for the IMU smoothing filter.
package imusf_pkg;

    localparam int AXES      = 3;
    localparam int AXIS_W    = $clog2(AXES);
    localparam int DATA_W    = 16;
    localparam int VAR_W     = 20;                 // Q4.16 variance
    localparam int GAIN_W    = 17;                 // Q1.16, up to 1.0
    localparam int EST_W     = 24;                 // Q16.8 estimate
    localparam int DIFF_W    = EST_W + 1;
    localparam int MUL_A_W   = GAIN_W + 1;
    localparam int PROD_W    = MUL_A_W + DIFF_W;
    localparam int DEN_W     = VAR_W + 1;
    localparam int REM_W     = DEN_W + 1;
    localparam int DIV_STEPS = GAIN_W;             // quotient bits
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W = 2;

    localparam logic [GAIN_W-1:0] ONE_Q16   = GAIN_W'(65536);
    localparam logic [VAR_W-1:0]  VAR_MAX   = {VAR_W{1'b1}};
    localparam logic [VAR_W-1:0]  COV_RESET = VAR_W'(1311);

    localparam logic [VAR_W-1:0]  PROCESS_NOISE_RESET = VAR_W'(66);
    localparam logic [VAR_W-1:0]  MEASURE_NOISE_RESET = VAR_W'(35586);
    localparam logic [GAIN_W-1:0] SMOOTH_ALPHA_RESET  = GAIN_W'(9830);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROCESS_NOISE = 2'd0,
        CFG_MEASURE_NOISE = 2'd1,
        CFG_SMOOTH_ALPHA  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic signed [DATA_W-1:0] gyro_x;
        logic signed [DATA_W-1:0] gyro_y;
        logic signed [DATA_W-1:0] gyro_z;
        logic signed [DATA_W-1:0] accel_x;
        logic signed [DATA_W-1:0] accel_y;
        logic signed [DATA_W-1:0] accel_z;
    } t_imu_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] filt_gyro_x;
        logic signed [DATA_W-1:0] filt_gyro_y;
        logic signed [DATA_W-1:0] filt_gyro_z;
        logic signed [DATA_W-1:0] filt_accel_x;
        logic signed [DATA_W-1:0] filt_accel_y;
        logic signed [DATA_W-1:0] filt_accel_z;
    } t_imu_out;

    typedef struct packed {
        logic              capture;
        logic              div_load;
        logic              div_step;
        logic              mul_gain;
        logic              upd_est;
        logic              upd_cov;
        logic              mul_alpha;
        logic              upd_avg;
        logic              load_out;
        logic [AXIS_W-1:0] axis;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage

// File: hw/rtl/imu_six_axis_smoothing_filter_top.sv
// IMU six-axis smoothing filter, top level.
// One six-axis sample in, one filtered sample out. Gyro axes run a scalar Kalman filter
// (Q4.16 covariance, Q16.8 estimate), accel axes an exponential smoother weighted by
// smooth_alpha; results are truncated toward zero to int16. An item is taken only while idle
// and runs to the end before the next is taken: per gyro axis a predict step, the shared
// one-bit-per-cycle gain divider and the multiply/update steps, then per accel axis a multiply
// and an update on the shared multiplier, then the output register load. A new sample is
// taken while the previous result still waits in the output register. Config writes are
// always ready and must only be issued while the block is idle.
module imu_six_axis_smoothing_filter_top
    import imusf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_imu_in              i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_imu_out             o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [VAR_W-1:0]     i_cfg_data
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    assign o_cfg_ready = 1'b1;

    imusf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    imusf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// File: hw/rtl/imusf_dp.sv
// Datapath: config registers, filter state, shared divider and multiplier, output register.
`include "imu_six_axis_smoothing_filter_top_macros.svh"

module imusf_dp
    import imusf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    input  t_imu_in              i_in_data,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [VAR_W-1:0]     i_cfg_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_imu_out             o_out_data
);

    localparam logic signed [PROD_W-1:0] Q16_BIAS = PROD_W'(65535);

    // Q16 product to a step, truncated toward zero.
    function automatic logic signed [DIFF_W-1:0] q16_step(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] adj;
        adj = p[PROD_W-1] ? p + Q16_BIAS : p;
        return DIFF_W'(adj >>> 16);
    endfunction

    // Q16.8 to int16, toward zero. A 24-bit estimate always fits, so no clamp is needed.
    function automatic logic signed [DATA_W-1:0] to_out(input logic signed [EST_W-1:0] e);
        logic [DATA_W-1:0] q;
        q = e[EST_W-1:8];
        if (e[EST_W-1] && (e[7:0] != 8'd0)) begin
            q = q + DATA_W'(1);
        end
        return $signed(q);
    endfunction

    logic [VAR_W-1:0]  r_process_noise;
    logic [VAR_W-1:0]  r_measure_noise;
    logic [GAIN_W-1:0] r_smooth_alpha;

    t_imu_in                  r_in;
    logic signed [EST_W-1:0]  r_est [AXES];
    logic [VAR_W-1:0]         r_cov [AXES];
    logic signed [EST_W-1:0]  r_avg [AXES];

    logic [VAR_W-1:0]         r_newp;
    logic [DEN_W-1:0]         r_den;
    logic                     r_den_zero;
    logic [REM_W-1:0]         r_rem;
    logic [GAIN_W-1:0]        r_dvd_lo;
    logic [GAIN_W-1:0]        r_quot;
    logic signed [PROD_W-1:0] r_prod;

    t_imu_out                 r_out;
    logic                     r_out_valid;

    logic signed [DATA_W-1:0] gyro_s  [AXES];
    logic signed [DATA_W-1:0] accel_s [AXES];

    logic [DEN_W-1:0]          cov_sum;
    logic [VAR_W-1:0]          newp;
    logic [DEN_W-1:0]          den;
    logic [REM_W-1:0]          rem_sh;
    logic                      quot_bit;
    logic [GAIN_W-1:0]         alpha_eff;
    logic signed [DIFF_W-1:0]  diff_gyro;
    logic signed [DIFF_W-1:0]  diff_accel;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [DIFF_W-1:0]  mul_b;
    logic                      mul_en;
    logic signed [DIFF_W-1:0]  step;

    assign gyro_s[0]  = r_in.gyro_x;
    assign gyro_s[1]  = r_in.gyro_y;
    assign gyro_s[2]  = r_in.gyro_z;
    assign accel_s[0] = r_in.accel_x;
    assign accel_s[1] = r_in.accel_y;
    assign accel_s[2] = r_in.accel_z;

    // Predicted covariance, saturated to Q4.16 range.
    assign cov_sum = {1'b0, r_cov[i_cmd.axis]} + {1'b0, r_process_noise};
    assign newp    = cov_sum[VAR_W] ? VAR_MAX : cov_sum[VAR_W-1:0];
    assign den     = {1'b0, newp} + {1'b0, r_measure_noise};

    // Restoring divider, one quotient bit per cycle.
    assign rem_sh   = {r_rem[REM_W-2:0], r_dvd_lo[GAIN_W-1]};
    assign quot_bit = !r_den_zero && (rem_sh >= {1'b0, r_den});

    assign alpha_eff  = (r_smooth_alpha > ONE_Q16) ? ONE_Q16 : r_smooth_alpha;
    assign diff_gyro  = $signed({gyro_s[i_cmd.axis][DATA_W-1], gyro_s[i_cmd.axis], 8'd0})
                      - $signed({r_est[i_cmd.axis][EST_W-1], r_est[i_cmd.axis]});
    assign diff_accel = $signed({accel_s[i_cmd.axis][DATA_W-1], accel_s[i_cmd.axis], 8'd0})
                      - $signed({r_avg[i_cmd.axis][EST_W-1], r_avg[i_cmd.axis]});

    // Operand select for the one shared multiplier.
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        if (i_cmd.mul_gain) begin
            mul_a = $signed({1'b0, r_quot});
            mul_b = diff_gyro;
        end else if (i_cmd.upd_est) begin
            mul_a = $signed({1'b0, ONE_Q16 - r_quot});
            mul_b = $signed({{(DIFF_W-VAR_W){1'b0}}, r_newp});
        end else if (i_cmd.mul_alpha) begin
            mul_a = $signed({1'b0, alpha_eff});
            mul_b = diff_accel;
        end else begin
            mul_en = 1'b0;
        end
    end

    assign step = q16_step(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_process_noise <= PROCESS_NOISE_RESET;
            r_measure_noise <= MEASURE_NOISE_RESET;
            r_smooth_alpha  <= SMOOTH_ALPHA_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PROCESS_NOISE: r_process_noise <= i_cfg_data;
                CFG_MEASURE_NOISE: r_measure_noise <= i_cfg_data;
                CFG_SMOOTH_ALPHA:  r_smooth_alpha  <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < AXES; a++) begin
                r_est[a] <= '0;
                r_cov[a] <= COV_RESET;
                r_avg[a] <= '0;
            end
        end else begin
            if (i_cmd.upd_est) begin
                r_est[i_cmd.axis] <= EST_W'(r_est[i_cmd.axis] + step);
            end
            if (i_cmd.upd_cov) begin
                r_cov[i_cmd.axis] <= r_prod[16 +: VAR_W];
            end
            if (i_cmd.upd_avg) begin
                r_avg[i_cmd.axis] <= EST_W'(r_avg[i_cmd.axis] + step);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_in_data;
        end
        if (i_cmd.div_load) begin
            r_newp     <= newp;
            r_den      <= den;
            r_den_zero <= (den == '0);
            r_rem      <= REM_W'(newp >> 1);
            r_dvd_lo   <= {newp[0], {(GAIN_W-1){1'b0}}};
            r_quot     <= '0;
        end else if (i_cmd.div_step) begin
            r_rem    <= quot_bit ? rem_sh - {1'b0, r_den} : rem_sh;
            r_dvd_lo <= r_dvd_lo << 1;
            r_quot   <= {r_quot[GAIN_W-2:0], quot_bit};
        end
        if (mul_en) begin
            r_prod <= PROD_W'(mul_a * mul_b);
        end
        if (i_cmd.load_out) begin
            r_out.filt_gyro_x  <= to_out(r_est[0]);
            r_out.filt_gyro_y  <= to_out(r_est[1]);
            r_out.filt_gyro_z  <= to_out(r_est[2]);
            r_out.filt_accel_x <= to_out(r_avg[0]);
            r_out.filt_accel_y <= to_out(r_avg[1]);
            r_out.filt_accel_z <= to_out(r_avg[2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out;

    `IMUSF_ASSERT(a_gain_le_one, i_clk, i_rst_n, i_cmd.mul_gain |-> (r_quot <= ONE_Q16), "gain above 1.0")
    `IMUSF_ASSERT(a_cov_prod_pos, i_clk, i_rst_n, i_cmd.upd_cov |-> !r_prod[PROD_W-1], "negative covariance product")
    `IMUSF_ASSERT(a_load_sets_valid, i_clk, i_rst_n, i_cmd.load_out |=> r_out_valid, "result load lost")
    `IMUSF_ASSERT_ALWAYS(a_rst_clears_valid, i_clk, !i_rst_n |=> !r_out_valid, "valid survives reset")

endmodule

// File: hw/rtl/imusf_ctrl.sv
// Controller: sequences the three Kalman axes, the three smoother axes and the result load.
`include "imu_six_axis_smoothing_filter_top_macros.svh"

module imusf_ctrl
    import imusf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_PRED  = 9'b000000010,
        S_DIV   = 9'b000000100,
        S_MGAIN = 9'b000001000,
        S_UEST  = 9'b000010000,
        S_UCOV  = 9'b000100000,
        S_AMUL  = 9'b001000000,
        S_AUPD  = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    localparam logic [AXIS_W-1:0] AXIS_LAST = AXIS_W'(AXES - 1);
    localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(DIV_STEPS - 1);

    t_state            r_state, n_state;
    logic [AXIS_W-1:0] r_axis, n_axis;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_axis  = r_axis;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.axis = r_axis;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_axis  = '0;
                    n_state = S_PRED;
                end
            end
            S_PRED: begin
                o_cmd.div_load = 1'b1;
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_MGAIN;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_MGAIN: begin
                o_cmd.mul_gain = 1'b1;
                n_state = S_UEST;
            end
            S_UEST: begin
                // estimate update; covariance product issued in the same cycle
                o_cmd.upd_est = 1'b1;
                n_state = S_UCOV;
            end
            S_UCOV: begin
                o_cmd.upd_cov = 1'b1;
                if (r_axis == AXIS_LAST) begin
                    n_axis  = '0;
                    n_state = S_AMUL;
                end else begin
                    n_axis  = r_axis + AXIS_W'(1);
                    n_state = S_PRED;
                end
            end
            S_AMUL: begin
                o_cmd.mul_alpha = 1'b1;
                n_state = S_AUPD;
            end
            S_AUPD: begin
                o_cmd.upd_avg = 1'b1;
                if (r_axis == AXIS_LAST) begin
                    n_axis  = '0;
                    n_state = S_DONE;
                end else begin
                    n_axis  = r_axis + AXIS_W'(1);
                    n_state = S_AMUL;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_axis  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
            r_cnt   <= n_cnt;
        end
    end

    `IMUSF_ASSERT(a_div_cnt_range, i_clk, i_rst_n, (r_state == S_DIV) |-> (r_cnt <= CNT_LAST), "divider count overrun")
    `IMUSF_ASSERT(a_gyro_to_accel, i_clk, i_rst_n, ((r_state == S_UCOV) && (r_axis == AXIS_LAST)) |=> ((r_state == S_AMUL) && (r_axis == '0)), "bad gyro to accel handoff")
    `IMUSF_ASSERT(a_load_when_free, i_clk, i_rst_n, o_cmd.load_out |-> i_sts.out_free, "result loaded over pending result")

endmodule
